@@ rtl/mtwg_pkg.sv @@
// Package for the MT19937 word generator: widths, recurrence constants,
// queue sizing and the request queue head type. No dependencies.
`default_nettype none

package mtwg_pkg;

    localparam int WORD_W      = 32;
    localparam int STATE_WORDS = 624;
    localparam int TAP_OFFSET  = 397;
    localparam int TAP_BACK    = STATE_WORDS - TAP_OFFSET;
    localparam int ADDR_W      = $clog2(STATE_WORDS);
    localparam int IDX_W       = $clog2(STATE_WORDS + 2);
    localparam int FILL_SHIFT  = 30;

    localparam logic [IDX_W-1:0]  NOT_INIT     = IDX_W'(STATE_WORDS + 1);
    localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] FILL_MULT    = 32'd1812433253;
    localparam logic [WORD_W-1:0] SEED_RESET   = 32'd5489;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // head of the request queue as seen by the engine
    typedef struct packed {
        logic valid;
        logic restart;
    } mtwg_qhead_t;

endpackage

`default_nettype wire

@@ rtl/mtwg_if.sv @@
// Channel interfaces: draw requests in, tempered words out.
// Depends on mtwg_pkg.
`default_nettype none

interface mtwg_req_if;
    logic valid;
    logic ready;
    logic restart;
    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface mtwg_word_if;
    logic                      valid;
    logic                      ready;
    logic [mtwg_pkg::WORD_W-1:0] random_word;
    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

`default_nettype wire

@@ rtl/mtwg_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mtwg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/mtwg_front.sv @@
// Front end: accepts draw requests and holds them in a short queue.
// Depends on mtwg_pkg and mtwg_req_if.
`default_nettype none

module mtwg_front (
    input  logic                  clk,
    input  logic                  rst_n,
    mtwg_req_if.sink              req,
    input  logic                  pop,
    output mtwg_pkg::mtwg_qhead_t head
);
    import mtwg_pkg::*;

    logic              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, take;

    assign req.ready    = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push         = req.valid && req.ready;
    assign take         = pop && (count_reg != '0);
    assign head.valid   = (count_reg != '0);
    assign head.restart = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = take ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !take)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (take && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= req.restart;
        end
    end

endmodule

`default_nettype wire

@@ rtl/mtwg_engine.sv @@
// Back end: seed fill, in-place twist, draw and tempering over the state RAM.
// Depends on mtwg_pkg, mtwg_word_if and mtwg_ram.
`default_nettype none

module mtwg_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         seed_we,
    input  logic [mtwg_pkg::WORD_W-1:0]  seed_wdata,
    input  mtwg_pkg::mtwg_qhead_t        head,
    output logic                         pop,
    mtwg_word_if.source                  rsp
);
    import mtwg_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_FILL_MUL = 9'b000000010,
        S_FILL_WR  = 9'b000000100,
        S_TW_PRIME = 9'b000001000,
        S_TW_NXT   = 9'b000010000,
        S_TW_TAP   = 9'b000100000,
        S_TW_WR    = 9'b001000000,
        S_RD_ADDR  = 9'b010000000,
        S_RD_DATA  = 9'b100000000
    } eng_state_t;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STATE_WORDS - 1);

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] v;
        v = w ^ (w >> 11);
        v = v ^ ((v << 7) & TEMPER_B);
        v = v ^ ((v << 15) & TEMPER_C);
        v = v ^ (v >> 18);
        return v;
    endfunction

    eng_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [WORD_W-1:0] seed_reg, seed_next;
    logic [WORD_W-1:0] work_reg, work_next;   // fill: previous word; twist: s[i]
    logic [WORD_W-1:0] prod_reg, prod_next;
    logic [WORD_W-1:0] nxt_reg, nxt_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_word_reg, out_word_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    logic [ADDR_W-1:0] nxt_addr, tap_addr;
    logic [WORD_W-1:0] fill_mix, fill_word;
    logic [WORD_W-1:0] joined, twisted;

    mtwg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STATE_WORDS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign nxt_addr  = (cnt_reg == LAST_ADDR) ? '0 : cnt_reg + ADDR_W'(1);
    assign tap_addr  = (cnt_reg < ADDR_W'(TAP_BACK)) ? cnt_reg + ADDR_W'(TAP_OFFSET)
                                                      : cnt_reg - ADDR_W'(TAP_BACK);
    assign fill_mix  = work_reg ^ (work_reg >> FILL_SHIFT);
    assign fill_word = prod_reg + WORD_W'(cnt_reg);
    assign joined    = {work_reg[WORD_W-1], nxt_reg[WORD_W-2:0]};
    assign twisted   = ram_rdata ^ (joined >> 1) ^ (joined[0] ? TWIST_MATRIX : '0);

    assign rsp.valid       = out_valid_reg;
    assign rsp.random_word = out_word_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        seed_next      = seed_reg;
        work_next      = work_reg;
        prod_next      = prod_reg;
        nxt_next       = nxt_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg;
        ram_wdata      = fill_word;
        ram_raddr      = cnt_reg;
        pop            = 1'b0;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (head.valid && !out_valid_reg)
                begin
                    pop = 1'b1;
                    if (head.restart || (idx_reg > IDX_W'(STATE_WORDS)))
                    begin
                        // word 0 is the seed itself
                        ram_we     = 1'b1;
                        ram_waddr  = '0;
                        ram_wdata  = seed_reg;
                        work_next  = seed_reg;
                        cnt_next   = ADDR_W'(1);
                        state_next = S_FILL_MUL;
                    end
                    else if (idx_reg == IDX_W'(STATE_WORDS))
                    begin
                        cnt_next   = '0;
                        state_next = S_TW_PRIME;
                    end
                    else
                    begin
                        state_next = S_RD_ADDR;
                    end
                end
            end
            S_FILL_MUL:
            begin
                prod_next  = FILL_MULT * fill_mix;
                state_next = S_FILL_WR;
            end
            S_FILL_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = fill_word;
                work_next = fill_word;
                if (cnt_reg == LAST_ADDR)
                begin
                    cnt_next   = '0;
                    state_next = S_TW_PRIME;
                end
                else
                begin
                    cnt_next   = cnt_reg + ADDR_W'(1);
                    state_next = S_FILL_MUL;
                end
            end
            S_TW_PRIME:
            begin
                ram_raddr  = '0;
                state_next = S_TW_NXT;
            end
            S_TW_NXT:
            begin
                if (cnt_reg == '0)
                begin
                    work_next = ram_rdata;
                end
                ram_raddr  = nxt_addr;
                state_next = S_TW_TAP;
            end
            S_TW_TAP:
            begin
                nxt_next   = ram_rdata;
                ram_raddr  = tap_addr;
                state_next = S_TW_WR;
            end
            S_TW_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = twisted;
                work_next = nxt_reg;
                if (cnt_reg == LAST_ADDR)
                begin
                    idx_next   = '0;
                    state_next = S_RD_ADDR;
                end
                else
                begin
                    cnt_next   = cnt_reg + ADDR_W'(1);
                    state_next = S_TW_NXT;
                end
            end
            S_RD_ADDR:
            begin
                ram_raddr  = idx_reg[ADDR_W-1:0];
                state_next = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                out_word_next  = temper(ram_rdata);
                out_valid_next = 1'b1;
                idx_next       = idx_reg + IDX_W'(1);
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (seed_we)
        begin
            seed_next = seed_wdata;
            idx_next  = NOT_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= NOT_INIT;
            seed_reg      <= SEED_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            seed_reg      <= seed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        prod_reg     <= prod_next;
        nxt_reg      <= nxt_next;
        out_word_reg <= out_word_next;
    end

endmodule

`default_nettype wire

@@ rtl/mt19937_word_generator.sv @@
// Top level of the MT19937 word generator: request queue plus engine.
// Depends on mtwg_pkg, mtwg_if, mtwg_front, mtwg_engine (and mtwg_ram).
//
// Usage
//   req  : draw requests (valid/ready); restart=1 refills the state from the
//          seed before this draw. One request yields exactly one word.
//   rsp  : tempered 32-bit words (valid/ready) in request order.
//   seed : seed_we/seed_wdata load the seed register; only while idle.
//          The new seed takes effect on the next request.
// Operation
//   A plain draw passes the engine states pop, RAM address and temper into
//   the output register. The engine pops the next request only once the
//   output register is empty, so it takes no new request until the last
//   word has been taken. Every 624th draw first runs the twist over the
//   single-write, single-read state RAM: a read of s[0], then per word the
//   reads of s[i+1] and s[i+397] and the write of s[i]. A fill from the
//   seed (first request after reset, after a seed write or on restart)
//   writes word 0 as the request is popped and then runs a multiply step
//   and an add-and-write step for each further word before that twist.
// Reset: seed returns to 5489 and the state is marked uninitialized; the
//   state RAM itself is not cleared.
// Stall: while rsp is held the engine keeps its word and waits; the front
//   queue still takes up to 4 requests.
`default_nettype none

module mt19937_word_generator (
    input  logic                        clk,
    input  logic                        rst_n,
    mtwg_req_if.sink                    req,
    mtwg_word_if.source                 rsp,
    input  logic                        seed_we,
    input  logic [mtwg_pkg::WORD_W-1:0] seed_wdata
);
    import mtwg_pkg::*;

    mtwg_qhead_t head;
    logic        pop;

    // front: request queue
    mtwg_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .pop   (pop),
        .head  (head)
    );

    // back: fill, twist, draw, temper
    mtwg_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_we    (seed_we),
        .seed_wdata (seed_wdata),
        .head       (head),
        .pop        (pop),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

@@ rtl/mtwg_checker.sv @@
// Port-level checks for the MT19937 word generator, bound to the top level.
// Depends on mtwg_pkg.
`default_nettype none

module mtwg_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [mtwg_pkg::WORD_W-1:0] out_word
);
    import mtwg_pkg::*;

    logic [3:0] pend_reg, pend_next;
    logic       in_take, out_take;

    assign in_take  = in_valid && in_ready;
    assign out_take = out_valid && out_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_take && !out_take)
        begin
            pend_next = pend_reg + 4'd1;
        end
        else if (out_take && !in_take)
        begin
            pend_next = pend_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_word_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_word))
        else $error("result word changed while stalled");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 4'd0)
        else $error("result without an open request");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result shown during reset");

endmodule

bind mt19937_word_generator mtwg_checker u_mtwg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_word  (rsp.random_word)
);

`default_nettype wire

@@ tb/mt19937_word_generator_tb.sv @@
// Self-checking bench for mt19937_word_generator: draw requests in, tempered words out.
// A local MT19937 model predicts words not typed in. Seed writes and idle/stall phases vary the run.
// Depends on mtwg_pkg, mtwg_if and the generator RTL.

module mt19937_word_generator_tb;

    import mtwg_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;   // engine is idle once the last word is out
    localparam int TAIL_CYCLES   = 16;  // catches stray words after the drain
    localparam int SHOW_LIMIT    = 10;
    localparam int PHASE_ITEMS   = 400;
    localparam int RESTART_PCT   = 2;   // a restart refills and twists the whole state, keep them rare

    // one row of the directed script
    typedef struct packed {
        logic              wr_seed;     // load seed_val while idle before this request
        logic [WORD_W-1:0] seed_val;
        logic              restart;
        logic              known;       // word is typed in below, not predicted
        logic [WORD_W-1:0] known_word;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic seed_we;
    logic [WORD_W-1:0] seed_wdata;

    mtwg_req_if  req_ch ();
    mtwg_word_if word_ch ();

    mt19937_word_generator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (word_ch),
        .seed_we    (seed_we),
        .seed_wdata (seed_wdata)
    );

    // Directed part. Known words are the well-known first outputs of MT19937
    // for seeds 5489 (the reset seed), 0 and 1.
    dir_row_t script [0:13] = '{
        // first request after reset fills from the reset seed
        '{1'b0, 32'd0,         1'b0, 1'b1, 32'd3499211612},
        '{1'b0, 32'd0,         1'b0, 1'b1, 32'd581869302},
        '{1'b0, 32'd0,         1'b0, 1'b1, 32'd3890346734},
        // restart rewinds to the start of the same sequence
        '{1'b0, 32'd0,         1'b1, 1'b1, 32'd3499211612},
        '{1'b0, 32'd0,         1'b0, 1'b1, 32'd581869302},
        // all-zero seed
        '{1'b1, 32'd0,         1'b0, 1'b1, 32'd2357136044},
        '{1'b0, 32'd0,         1'b0, 1'b0, 32'd0},
        // seed write followed by a restart on the very next request
        '{1'b1, 32'd1,         1'b0, 1'b1, 32'd1791095845},
        '{1'b0, 32'd0,         1'b1, 1'b1, 32'd1791095845},
        // all-ones seed
        '{1'b1, 32'hffff_ffff, 1'b0, 1'b0, 32'd0},
        '{1'b0, 32'd0,         1'b0, 1'b0, 32'd0},
        '{1'b0, 32'd0,         1'b1, 1'b0, 32'd0},
        // write back the reset seed, with restart on the same request
        '{1'b1, SEED_RESET,    1'b1, 1'b1, 32'd3499211612},
        '{1'b0, 32'd0,         1'b0, 1'b1, 32'd581869302}
    };

    // idling per random phase: none, sender gaps, receiver stalls, both
    int unsigned gap_by_phase   [0:3] = '{0, 75, 0, 17};
    int unsigned stall_by_phase [0:3] = '{0, 0, 75, 17};

    int unsigned req_gap_pct;
    int unsigned rsp_stall_pct;
    int unsigned bad_count;
    int unsigned cycle_count;

    // words still owed by the generator, oldest first
    logic [WORD_W-1:0] pending_words [$];

    // ---- MT19937 model state ----
    logic [WORD_W-1:0] mt_seed;
    logic [WORD_W-1:0] mt_words [0:STATE_WORDS-1];
    int unsigned       mt_pos;  // STATE_WORDS+1 means not filled yet

    // linear fill from the seed
    function automatic void mt_fill();
        logic [WORD_W-1:0] prev;
        mt_words[0] = mt_seed;
        for (int i = 1; i < STATE_WORDS; i++)
        begin
            prev        = mt_words[i-1];
            mt_words[i] = FILL_MULT * (prev ^ (prev >> FILL_SHIFT)) + WORD_W'(i);
        end
        mt_pos = STATE_WORDS;
    endfunction

    // regenerate all words in place; later words see already-twisted early ones
    function automatic void mt_twist();
        logic [WORD_W-1:0] joined;
        logic [WORD_W-1:0] nv;
        for (int i = 0; i < STATE_WORDS; i++)
        begin
            joined = {mt_words[i][WORD_W-1], mt_words[(i + 1) % STATE_WORDS][WORD_W-2:0]};
            nv     = mt_words[(i + TAP_OFFSET) % STATE_WORDS] ^ (joined >> 1);
            if (joined[0])
            begin
                nv ^= TWIST_MATRIX;
            end
            mt_words[i] = nv;
        end
        mt_pos = 0;
    endfunction

    function automatic logic [WORD_W-1:0] mt_temper(input logic [WORD_W-1:0] raw);
        logic [WORD_W-1:0] v;
        v = raw;
        v ^= v >> 11;
        v ^= (v << 7) & TEMPER_B;
        v ^= (v << 15) & TEMPER_C;
        v ^= v >> 18;
        return v;
    endfunction

    // next word for one request
    function automatic logic [WORD_W-1:0] mt_draw(input logic restart);
        logic [WORD_W-1:0] raw;
        if (restart || mt_pos > STATE_WORDS)
        begin
            mt_fill();
        end
        if (mt_pos >= STATE_WORDS)
        begin
            mt_twist();
        end
        raw    = mt_words[mt_pos];
        mt_pos = mt_pos + 1;
        return mt_temper(raw);
    endfunction

    function automatic void flag_bad(input string what, input logic [WORD_W-1:0] want,
                                     input logic [WORD_W-1:0] got);
        bad_count++;
        if (bad_count <= SHOW_LIMIT)
        begin
            $display("%s: expected %08h got %08h", what, want, got);
        end
    endfunction

    // ---- clock and watchdog ----
    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---- word side: check what was taken at this edge, then pick next ready ----
    // Values read here are the ones present at the edge; the new ready lands
    // in the NBA region, so there is no ordering hazard with the DUT.
    always @(posedge clk)
    begin
        if (rst_n && word_ch.valid && word_ch.ready)
        begin
            if (pending_words.size() == 0)
            begin
                flag_bad("word with no request pending", 'x, word_ch.random_word);
            end
            else if (word_ch.random_word !== pending_words[0])
            begin
                flag_bad("random_word mismatch", pending_words[0], word_ch.random_word);
                void'(pending_words.pop_front());
            end
            else
            begin
                void'(pending_words.pop_front());
            end
        end
        word_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
    end

    // ---- request side ----
    // Called at a rising edge; returns at the edge where the request was taken.
    // valid gets exactly one NBA per time step, so back-to-back requests keep it high.
    task automatic push_draw(input logic restart, input logic known,
                             input logic [WORD_W-1:0] known_word);
        logic [WORD_W-1:0] predicted;
        while ($urandom_range(0, 99) < req_gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.restart <= restart;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        // taken at this edge: advance the model even when the word is typed in
        predicted = mt_draw(restart);
        pending_words.push_back(known ? known_word : predicted);
    endtask

    // hold off requests until every owed word has come back
    task automatic drain_words();
        req_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_words.size() != 0);
    endtask

    // seed writes only with the engine idle
    task automatic load_seed(input logic [WORD_W-1:0] value);
        drain_words();
        repeat (SETTLE_CYCLES) @(posedge clk);
        seed_we    <= 1'b1;
        seed_wdata <= value;
        @(posedge clk);
        seed_we <= 1'b0;
        mt_seed = value;
        mt_pos  = NOT_INIT;
    endtask

    // ---- main sequence ----
    initial
    begin
        logic [WORD_W-1:0] phase_seed;

        req_ch.valid   = 1'b0;
        req_ch.restart = 1'b0;
        word_ch.ready  = 1'b0;
        seed_we        = 1'b0;
        seed_wdata     = '0;
        req_gap_pct    = 0;
        rsp_stall_pct  = 0;
        bad_count      = 0;
        cycle_count    = 0;
        mt_seed        = SEED_RESET;
        mt_pos         = NOT_INIT;

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows, no idling
        for (int r = 0; r <= 13; r++)
        begin
            if (script[r].wr_seed)
            begin
                load_seed(script[r].seed_val);
            end
            push_draw(script[r].restart, script[r].known, script[r].known_word);
        end

        // random phases: a fresh seed each, mostly plain draws, a few restarts
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       phase_seed = '0;
                1:       phase_seed = '1;
                default: phase_seed = $urandom;
            endcase
            load_seed(phase_seed);
            req_gap_pct   = gap_by_phase[p];
            rsp_stall_pct = stall_by_phase[p];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // now and then let the pipe run dry mid-sequence
                if ($urandom_range(0, 199) == 0)
                begin
                    drain_words();
                end
                push_draw($urandom_range(0, 99) < RESTART_PCT, 1'b0, '0);
            end
        end

        drain_words();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (bad_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/mtwg_pkg.sv
rtl/mtwg_if.sv
rtl/mtwg_ram.sv
rtl/mtwg_front.sv
rtl/mtwg_engine.sv
rtl/mt19937_word_generator.sv
rtl/mtwg_checker.sv
tb/mt19937_word_generator_tb.sv
